// File: hdl/tci_pkg.sv
package tci_pkg;

    typedef enum logic [3:0] {
        PH_PRE  = 4'd0,
        PH_SID  = 4'd1,
        PH_CLEN = 4'd2,
        PH_CIPH = 4'd3,
        PH_COMP = 4'd4,
        PH_ELEN = 4'd5,
        PH_EXT  = 4'd6,
        PH_DEAD = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_TLS13   = 2'd1,
        CLS_STRONG  = 2'd2,
        CLS_WEAK    = 2'd3
    } suite_class_t;

    typedef enum logic [2:0] {
        VER_UNKNOWN = 3'd0,
        VER_TLS10   = 3'd1,
        VER_TLS11   = 3'd2,
        VER_TLS12   = 3'd3,
        VER_TLS13   = 3'd4
    } version_t;

    localparam logic       KIND_SUITE   = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;

    localparam logic [7:0]  REC_HANDSHAKE  = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] GREASE_MASK    = 16'h0F0F;
    localparam logic [15:0] GREASE_VALUE   = 16'h0A0A;
    localparam logic [15:0] EXT_SNI        = 16'h0000;
    localparam logic [15:0] EXT_SUP_VER    = 16'h002B;
    localparam int unsigned SID_LEN_OFFSET = 43;

    typedef struct packed {
        logic         item_kind;
        logic [15:0]  suite_code;
        suite_class_t suite_class;
        logic         is_handshake;
        version_t     version_code;
        logic         weak_version;
        logic         hs_present;
        logic [7:0]   hs_type;
        logic         sni_present;
        logic         run_last;
    } result_t;

    function automatic suite_class_t suite_class_of(input logic [15:0] code);
        suite_class_t c;
        c = CLS_UNKNOWN;
        unique case (code)
            16'h1301, 16'h1302, 16'h1303: c = CLS_TLS13;
            16'hC02B, 16'hC02C, 16'hC02F, 16'hC030,
            16'hCCA8, 16'hCCA9: c = CLS_STRONG;
            16'h0035, 16'h002F, 16'h000A, 16'h0005, 16'h0004: c = CLS_WEAK;
            default: c = CLS_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic version_t ver_class(input logic [15:0] v);
        version_t r;
        r = VER_UNKNOWN;
        if (v[15:8] == 8'd3 && v[7:0] >= 8'd1 && v[7:0] <= 8'd4)
        begin
            r = version_t'(v[2:0]);
        end
        return r;
    endfunction

endpackage

// File: hdl/tls_client_hello_inspector.sv
// An accepted byte waits in the input register until the queue has room for two
//   results; it is then parsed and its results enter the queue, offered to the sink.
// Throughput: one byte per cycle while results drain at one per cycle; the
//   four-entry result queue and its single read port set that figure.
// Reset: rst_n clears the parser to the record header phase and empties queue.
module tls_client_hello_inspector #(
    parameter int OFFSET_BITS = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pkt_byte,
    input  logic        pkt_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        item_kind,
    output logic [15:0] suite_code,
    output logic [1:0]  suite_class,
    output logic        is_handshake,
    output logic [2:0]  version_code,
    output logic        weak_version,
    output logic        hs_present,
    output logic [7:0]  hs_type,
    output logic        sni_present,
    output logic        run_last
);

    // input register: holds one byte until the queue has room for two results
    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       in_take;
    logic       fire;

    logic [1:0]       res_cnt;
    tci_pkg::result_t res0, res1, head;
    logic [2:0]       q_count;
    logic             q_rd;

    // a byte may yield a suite report and a summary, so keep two slots free
    assign fire     = in_vld_reg && (q_count <= 3'd2);
    assign in_stall = in_vld_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        priority if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
        else
        begin
            in_vld_next = in_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= pkt_byte;
            last_reg <= pkt_last;
        end
    end

    tci_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .pkt_byte (byte_reg),
        .pkt_last (last_reg),
        .res_cnt  (res_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    // results queue; the head entry is the output register seen by the sink
    tci_result_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_cnt  (fire ? res_cnt : 2'd0),
        .wr0     (res0),
        .wr1     (res1),
        .rd      (q_rd),
        .rd_data (head),
        .count   (q_count)
    );

    assign out_valid    = (q_count != 3'd0);
    assign q_rd         = out_valid && !out_stall;
    assign item_kind    = head.item_kind;
    assign suite_code   = head.suite_code;
    assign suite_class  = head.suite_class;
    assign is_handshake = head.is_handshake;
    assign version_code = head.version_code;
    assign weak_version = head.weak_version;
    assign hs_present   = head.hs_present;
    assign hs_type      = head.hs_type;
    assign sni_present  = head.sni_present;
    assign run_last     = head.run_last;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n) q_count <= 3'd4)
        else $error("result queue overflow");

    // a held byte stays put until parsed
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> in_vld_reg && $stable(byte_reg) && $stable(last_reg))
        else $error("held input byte lost");

    // a summary always closes the run of results for its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind |-> run_last)
        else $error("summary without run_last");

endmodule

// File: hdl/tci_parser.sv
module tci_parser #(
    parameter int OFFSET_BITS = 17
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic [7:0]         pkt_byte,
    input  logic               pkt_last,
    output logic [1:0]         res_cnt,
    output tci_pkg::result_t   res0,
    output tci_pkg::result_t   res1
);

    localparam int OB = OFFSET_BITS;
    localparam int SW = ((OB > 16) ? OB : 16) + 2;
    localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};

    function automatic logic [OB-1:0] sat_off(input logic [SW-1:0] v);
        logic [OB-1:0] r;
        r = (v > SW'(OFF_MAX)) ? OFF_MAX : v[OB-1:0];
        return r;
    endfunction

    logic [OB-1:0]     off_reg, off_next;
    tci_pkg::phase_t   phase_reg, phase_next;
    logic [15:0]       rec_ver_reg, rec_ver_next;
    logic [15:0]       cli_ver_reg, cli_ver_next;
    logic [7:0]        hello_reg, hello_next;
    logic              hdr_ok_reg, hdr_ok_next;
    logic [OB-1:0]     reg_end_reg, reg_end_next;
    logic [OB-1:0]     list_end_reg, list_end_next;
    logic [31:0]       ext_hdr_reg, ext_hdr_next;
    logic [7:0]        held_reg, held_next;
    logic              sv_wait_reg, sv_wait_next;
    logic [7:0]        sv_left_reg, sv_left_next;
    logic [7:0]        sv_first_reg, sv_first_next;
    logic              t13_reg, t13_next;
    logic [OB-1:0]     t13_end_reg, t13_end_next;
    logic              sni_reg, sni_next;

    // values after this byte, before the end-of-packet clear
    tci_pkg::phase_t   st_phase;
    logic [15:0]       st_rec_ver, st_cli_ver;
    logic [7:0]        st_hello, st_held, st_sv_left, st_sv_first;
    logic              st_hdr_ok, st_sv_wait, st_t13, st_sni;
    logic [OB-1:0]     st_reg_end, st_list_end, st_t13_end;
    logic [31:0]       st_ext_hdr;

    logic [OB-1:0]     cur;
    logic              live;
    logic [OB:0]       cnt;
    logic [SW-1:0]     cur1;
    logic [31:0]       hdr_shift;

    assign cur  = off_reg;
    assign live = (cur != OFF_MAX);
    assign cnt  = {1'b0, cur} + (OB+1)'(1);
    assign cur1 = SW'(cur) + SW'(1);
    assign hdr_shift = {ext_hdr_reg[23:0], pkt_byte};

    always_comb
    begin
        st_phase    = phase_reg;
        st_rec_ver  = rec_ver_reg;
        st_cli_ver  = cli_ver_reg;
        st_hello    = hello_reg;
        st_hdr_ok   = hdr_ok_reg;
        st_reg_end  = reg_end_reg;
        st_list_end = list_end_reg;
        st_ext_hdr  = ext_hdr_reg;
        st_held     = held_reg;
        st_sv_wait  = sv_wait_reg;
        st_sv_left  = sv_left_reg;
        st_sv_first = sv_first_reg;
        st_t13      = t13_reg;
        st_t13_end  = t13_end_reg;
        st_sni      = sni_reg;
        if (live)
        begin
            // version list scan
            if (sv_wait_reg)
            begin
                st_sv_wait = 1'b0;
                st_sv_left = pkt_byte & 8'hFE;
            end
            else if (sv_left_reg != 8'd0)
            begin
                if (!sv_left_reg[0])
                begin
                    st_sv_first = pkt_byte;
                    st_sv_left  = sv_left_reg - 8'd1;
                end
                else if (sv_first_reg == 8'd3 && pkt_byte == 8'd4)
                begin
                    st_t13     = 1'b1;
                    st_sv_left = 8'd0;
                end
                else
                begin
                    st_sv_left = sv_left_reg - 8'd1;
                end
            end
            unique case (phase_reg)
                tci_pkg::PH_PRE:
                begin
                    if (cur == OB'(0))
                    begin
                        st_hdr_ok = (pkt_byte == tci_pkg::REC_HANDSHAKE);
                        if (pkt_byte != tci_pkg::REC_HANDSHAKE)
                        begin
                            st_phase = tci_pkg::PH_DEAD;
                        end
                    end
                    else if (cur == OB'(1))
                    begin
                        st_rec_ver = {pkt_byte, 8'd0};
                    end
                    else if (cur == OB'(2))
                    begin
                        st_rec_ver = {rec_ver_reg[15:8], pkt_byte};
                    end
                    else if (cur == OB'(5))
                    begin
                        st_hello = pkt_byte;
                        if (pkt_byte != tci_pkg::HS_CLIENT_HELLO)
                        begin
                            st_phase = tci_pkg::PH_DEAD;
                        end
                    end
                    else if (cur == OB'(9))
                    begin
                        st_cli_ver = {pkt_byte, 8'd0};
                    end
                    else if (cur == OB'(10))
                    begin
                        st_cli_ver = {cli_ver_reg[15:8], pkt_byte};
                    end
                    else if (cur == OB'(tci_pkg::SID_LEN_OFFSET))
                    begin
                        st_reg_end = sat_off(cur1 + SW'(pkt_byte));
                        st_phase   = tci_pkg::PH_SID;
                    end
                end
                tci_pkg::PH_SID:
                begin
                    if (cur == reg_end_reg)
                    begin
                        st_held  = pkt_byte;
                        st_phase = tci_pkg::PH_CLEN;
                    end
                end
                tci_pkg::PH_CLEN:
                begin
                    st_list_end = cur + OB'(1);
                    st_reg_end  = sat_off(cur1 + SW'({held_reg, pkt_byte} & 16'hFFFE));
                    st_phase    = tci_pkg::PH_CIPH;
                end
                tci_pkg::PH_CIPH:
                begin
                    if (cur == reg_end_reg)
                    begin
                        st_reg_end = sat_off(cur1 + SW'(pkt_byte));
                        st_phase   = tci_pkg::PH_COMP;
                    end
                    else if (cur[0] == list_end_reg[0])
                    begin
                        st_held = pkt_byte;
                    end
                end
                tci_pkg::PH_COMP:
                begin
                    if (cur == reg_end_reg)
                    begin
                        st_held  = pkt_byte;
                        st_phase = tci_pkg::PH_ELEN;
                    end
                end
                tci_pkg::PH_ELEN:
                begin
                    st_list_end = sat_off(cur1 + SW'({held_reg, pkt_byte}));
                    st_reg_end  = cur + OB'(1);
                    st_ext_hdr  = 32'd0;
                    st_phase    = tci_pkg::PH_EXT;
                end
                tci_pkg::PH_EXT:
                begin
                    if (cur >= reg_end_reg)
                    begin
                        if (cur == reg_end_reg &&
                            ({1'b0, reg_end_reg} + (OB+1)'(4)) > {1'b0, list_end_reg})
                        begin
                            st_phase = tci_pkg::PH_DEAD;
                        end
                        else
                        begin
                            st_ext_hdr = hdr_shift;
                            if ({1'b0, cur} == {1'b0, reg_end_reg} + (OB+1)'(3))
                            begin
                                st_reg_end = sat_off(cur1 + SW'(hdr_shift[15:0]));
                                if (hdr_shift[31:16] == tci_pkg::EXT_SNI)
                                begin
                                    st_sni = 1'b1;
                                end
                                if (hdr_shift[31:16] == tci_pkg::EXT_SUP_VER)
                                begin
                                    st_sv_wait = 1'b1;
                                    st_sv_left = 8'd0;
                                    if (!st_t13)
                                    begin
                                        st_t13_end = sat_off(cur1 + SW'(hdr_shift[15:0]));
                                    end
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (pkt_last)
        begin
            off_next      = '0;
            phase_next    = tci_pkg::PH_PRE;
            rec_ver_next  = '0;
            cli_ver_next  = '0;
            hello_next    = '0;
            hdr_ok_next   = 1'b0;
            reg_end_next  = '0;
            list_end_next = '0;
            ext_hdr_next  = '0;
            held_next     = '0;
            sv_wait_next  = 1'b0;
            sv_left_next  = '0;
            sv_first_next = '0;
            t13_next      = 1'b0;
            t13_end_next  = '0;
            sni_next      = 1'b0;
        end
        else
        begin
            off_next      = live ? (cur + OB'(1)) : cur;
            phase_next    = st_phase;
            rec_ver_next  = st_rec_ver;
            cli_ver_next  = st_cli_ver;
            hello_next    = st_hello;
            hdr_ok_next   = st_hdr_ok;
            reg_end_next  = st_reg_end;
            list_end_next = st_list_end;
            ext_hdr_next  = st_ext_hdr;
            held_next     = st_held;
            sv_wait_next  = st_sv_wait;
            sv_left_next  = st_sv_left;
            sv_first_next = st_sv_first;
            t13_next      = st_t13;
            t13_end_next  = st_t13_end;
            sni_next      = st_sni;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg      <= '0;
            phase_reg    <= tci_pkg::PH_PRE;
            rec_ver_reg  <= '0;
            cli_ver_reg  <= '0;
            hello_reg    <= '0;
            hdr_ok_reg   <= 1'b0;
            reg_end_reg  <= '0;
            list_end_reg <= '0;
            ext_hdr_reg  <= '0;
            held_reg     <= '0;
            sv_wait_reg  <= 1'b0;
            sv_left_reg  <= '0;
            sv_first_reg <= '0;
            t13_reg      <= 1'b0;
            t13_end_reg  <= '0;
            sni_reg      <= 1'b0;
        end
        else if (fire)
        begin
            off_reg      <= off_next;
            phase_reg    <= phase_next;
            rec_ver_reg  <= rec_ver_next;
            cli_ver_reg  <= cli_ver_next;
            hello_reg    <= hello_next;
            hdr_ok_reg   <= hdr_ok_next;
            reg_end_reg  <= reg_end_next;
            list_end_reg <= list_end_next;
            ext_hdr_reg  <= ext_hdr_next;
            held_reg     <= held_next;
            sv_wait_reg  <= sv_wait_next;
            sv_left_reg  <= sv_left_next;
            sv_first_reg <= sv_first_next;
            t13_reg      <= t13_next;
            t13_end_reg  <= t13_end_next;
            sni_reg      <= sni_next;
        end
    end

    // result assembly
    logic              suite_hit;
    logic [15:0]       code;
    tci_pkg::result_t  suite_res, sum_res;
    logic              hs, hsp;
    tci_pkg::version_t ver, cv;
    logic              weak_ver;

    assign code = {held_reg, pkt_byte};

    always_comb
    begin
        suite_hit = live && (phase_reg == tci_pkg::PH_CIPH) && (cur != reg_end_reg) &&
                    (cur[0] != list_end_reg[0]) &&
                    ((code & tci_pkg::GREASE_MASK) != tci_pkg::GREASE_VALUE);
        suite_res             = '0;
        suite_res.item_kind   = tci_pkg::KIND_SUITE;
        suite_res.suite_code  = code;
        suite_res.suite_class = tci_pkg::suite_class_of(code);
        suite_res.run_last    = !pkt_last;

        hs       = st_hdr_ok && (cnt >= (OB+1)'(5));
        hsp      = hs && (cnt >= (OB+1)'(6));
        ver      = tci_pkg::VER_UNKNOWN;
        weak_ver = 1'b0;
        cv       = tci_pkg::ver_class(st_cli_ver);
        if (hs)
        begin
            ver      = tci_pkg::ver_class(st_rec_ver);
            weak_ver = (ver == tci_pkg::VER_TLS10) || (ver == tci_pkg::VER_TLS11);
            if (hsp && st_hello == tci_pkg::HS_CLIENT_HELLO &&
                cnt >= (OB+1)'(tci_pkg::SID_LEN_OFFSET) && cv != tci_pkg::VER_UNKNOWN)
            begin
                ver = cv;
                if (cv == tci_pkg::VER_TLS10 || cv == tci_pkg::VER_TLS11)
                begin
                    weak_ver = 1'b1;
                end
            end
            if (st_t13 && ({1'b0, st_t13_end} <= cnt))
            begin
                ver      = tci_pkg::VER_TLS13;
                weak_ver = 1'b0;
            end
        end
        sum_res              = '0;
        sum_res.item_kind    = tci_pkg::KIND_SUMMARY;
        sum_res.is_handshake = hs;
        sum_res.version_code = ver;
        sum_res.weak_version = weak_ver;
        sum_res.hs_present   = hsp;
        sum_res.hs_type      = hsp ? st_hello : 8'd0;
        sum_res.sni_present  = hs && st_sni;
        sum_res.run_last     = 1'b1;

        res0    = suite_hit ? suite_res : sum_res;
        res1    = sum_res;
        res_cnt = {1'b0, suite_hit} + {1'b0, pkt_last};
    end

endmodule

// File: hdl/tci_result_fifo.sv
module tci_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        wr_cnt,
    input  tci_pkg::result_t  wr0,
    input  tci_pkg::result_t  wr1,
    input  logic              rd,
    output tci_pkg::result_t  rd_data,
    output logic [2:0]        count
);

    tci_pkg::result_t mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;

    assign wr_ptr_next = wr_ptr_reg + wr_cnt;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, rd};
    assign cnt_next    = cnt_reg + {1'b0, wr_cnt} - {2'b0, rd};
    assign rd_data     = mem[rd_ptr_reg];
    assign count       = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr0;
        end
        if (wr_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= wr1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
